// File: rtl/integer_to_ascii_digits_assert.svh
// Assertion macros used by the checker of integer_to_ascii_digits.
// Each macro expects clk and rst_n in scope.
`ifndef INTEGER_TO_ASCII_DIGITS_ASSERT_SVH
`define INTEGER_TO_ASCII_DIGITS_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define I2A_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define I2A_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/i2a_pkg.sv
// Package for integer_to_ascii_digits: payload structs, command codes,
// cell control types and the digit-to-character mapping. No dependencies.
`timescale 1ns / 1ps

package i2a_pkg;

  localparam int NUM_CELLS    = 16;
  localparam int DIGIT_W      = 4;
  localparam int BIN_W        = 32;
  localparam int DEC_DIGITS   = 10;
  localparam int HEX32_DIGITS = 8;
  localparam int HEX64_DIGITS = 16;

  localparam logic [2:0] CMD_SDEC = 3'd0;
  localparam logic [2:0] CMD_UDEC = 3'd1;
  localparam logic [2:0] CMD_HEXL = 3'd2;
  localparam logic [2:0] CMD_HEXU = 3'd3;
  localparam logic [2:0] CMD_PTR  = 3'd4;

  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_X     = 7'h78;
  localparam logic [6:0] CH_LOW_A = 7'h61;
  localparam logic [6:0] CH_UP_A  = 7'h41;

  typedef struct packed {
    logic [63:0] value;
    logic [2:0]  command;
  } in_item_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_LOAD   = 2'd1,
    CELL_DABBLE = 2'd2,
    CELL_SHIFT  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     load_lo;  // lower cells take their nibble on load, else zero
    logic     load_hi;  // upper cells take their nibble on load, else zero
    logic     ser_bit;  // binary bit entering cell 0 during double dabble
  } cell_ctrl_t;

  function automatic logic [6:0] digit_char(input logic [DIGIT_W-1:0] d,
                                            input logic upper);
    logic [6:0] base;
    base = upper ? CH_UP_A : CH_LOW_A;
    if (d < 4'd10) begin
      digit_char = CH_ZERO + {3'b000, d};
    end else begin
      digit_char = base + {3'b000, d} - 7'd10;
    end
  endfunction

endpackage

// File: rtl/i2a_cell.sv
// One digit cell of the conversion row: holds a 4-bit digit, loads it,
// runs a double-dabble step or takes its lower neighbor's digit. Uses i2a_pkg.
`timescale 1ns / 1ps

module i2a_cell (
  input  logic                           clk,
  input  i2a_pkg::cell_ctrl_t            ctrl,
  input  logic                           load_en,
  input  logic [i2a_pkg::DIGIT_W-1:0]    load_digit,
  input  logic                           bit_in,
  input  logic [i2a_pkg::DIGIT_W-1:0]    digit_in,
  output logic [i2a_pkg::DIGIT_W-1:0]    digit,
  output logic                           bit_out
);
  import i2a_pkg::*;

  logic [DIGIT_W-1:0] digit_r;
  logic [DIGIT_W-1:0] digit_nxt;
  logic [DIGIT_W-1:0] adj;

  // add 3 before the shift so the BCD digit carries at ten
  assign adj     = (digit_r >= 4'd5) ? digit_r + 4'd3 : digit_r;
  assign bit_out = adj[DIGIT_W-1];
  assign digit   = digit_r;

  always_comb begin
    unique case (ctrl.op)
      CELL_HOLD:   digit_nxt = digit_r;
      CELL_LOAD:   digit_nxt = load_en ? load_digit : '0;
      CELL_DABBLE: digit_nxt = {adj[DIGIT_W-2:0], bit_in};
      CELL_SHIFT:  digit_nxt = digit_in;
      default:     digit_nxt = digit_r;
    endcase
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

// File: rtl/i2a_ctrl.sv
// Sequencer for integer_to_ascii_digits: command decode, binary shift
// register, leading-zero skip, prefix and digit emission, output register.
// Uses i2a_pkg.
`timescale 1ns / 1ps

module i2a_ctrl (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            in_valid,
  output logic                                            in_ready,
  input  i2a_pkg::in_item_t                               in_payload,
  output logic                                            out_valid,
  input  logic                                            out_ready,
  output i2a_pkg::out_item_t                              out_payload,
  input  logic [i2a_pkg::NUM_CELLS-1:0][i2a_pkg::DIGIT_W-1:0] digits,
  output i2a_pkg::cell_ctrl_t                             cell_ctrl
);
  import i2a_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CONV   = 5'b00010,
    ST_SKIP   = 5'b00100,
    ST_PREFIX = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  localparam logic [3:0] TOP_DEC   = 4'(DEC_DIGITS - 1);
  localparam logic [3:0] TOP_HEX32 = 4'(HEX32_DIGITS - 1);
  localparam logic [3:0] TOP_HEX64 = 4'(HEX64_DIGITS - 1);

  state_t            state_r, state_nxt;
  logic [BIN_W-1:0]  bin_r, bin_nxt;
  logic [4:0]        bit_cnt_r, bit_cnt_nxt;
  logic [4:0]        rem_r, rem_nxt;
  logic [3:0]        top_sel_r, top_sel_nxt;
  logic [1:0]        pfx_r, pfx_nxt;
  logic              ptr_r, ptr_nxt;
  logic              upper_r, upper_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic              accept;
  logic              out_free;
  logic [DIGIT_W-1:0] top_digit;
  logic [BIN_W-1:0]  low_word;
  logic [BIN_W-1:0]  neg_word;

  assign in_ready    = (state_r == ST_IDLE);
  assign accept      = in_valid && in_ready;
  assign out_free    = !out_valid_r || out_ready;
  assign top_digit   = digits[top_sel_r];
  assign low_word    = in_payload.value[BIN_W-1:0];
  assign neg_word    = BIN_W'(0) - low_word;
  assign out_valid   = out_valid_r;
  assign out_payload = out_item_r;

  always_comb begin
    state_nxt     = state_r;
    bin_nxt       = bin_r;
    bit_cnt_nxt   = bit_cnt_r;
    rem_nxt       = rem_r;
    top_sel_nxt   = top_sel_r;
    pfx_nxt       = pfx_r;
    ptr_nxt       = ptr_r;
    upper_nxt     = upper_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    cell_ctrl     = '{op: CELL_HOLD, load_lo: 1'b0, load_hi: 1'b0, ser_bit: 1'b0};

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_payload.command)
            CMD_SDEC, CMD_UDEC: begin
              cell_ctrl.op = CELL_LOAD;
              if (in_payload.command == CMD_SDEC && low_word[BIN_W-1]) begin
                bin_nxt = neg_word;
                pfx_nxt = 2'd1;
              end else begin
                bin_nxt = low_word;
                pfx_nxt = 2'd0;
              end
              bit_cnt_nxt = 5'(BIN_W - 1);
              rem_nxt     = 5'(DEC_DIGITS);
              top_sel_nxt = TOP_DEC;
              ptr_nxt     = 1'b0;
              upper_nxt   = 1'b0;
              state_nxt   = ST_CONV;
            end
            CMD_HEXL, CMD_HEXU: begin
              cell_ctrl.op      = CELL_LOAD;
              cell_ctrl.load_lo = 1'b1;
              rem_nxt           = 5'(HEX32_DIGITS);
              top_sel_nxt       = TOP_HEX32;
              pfx_nxt           = 2'd0;
              ptr_nxt           = 1'b0;
              upper_nxt         = (in_payload.command == CMD_HEXU);
              state_nxt         = ST_SKIP;
            end
            CMD_PTR: begin
              cell_ctrl.op      = CELL_LOAD;
              cell_ctrl.load_lo = 1'b1;
              cell_ctrl.load_hi = 1'b1;
              rem_nxt           = 5'(HEX64_DIGITS);
              top_sel_nxt       = TOP_HEX64;
              pfx_nxt           = 2'd2;
              ptr_nxt           = 1'b1;
              upper_nxt         = 1'b0;
              state_nxt         = ST_SKIP;
            end
            default: begin
              // undefined command: drop the item
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_CONV: begin
        cell_ctrl.op      = CELL_DABBLE;
        cell_ctrl.ser_bit = bin_r[BIN_W-1];
        bin_nxt           = {bin_r[BIN_W-2:0], 1'b0};
        bit_cnt_nxt       = bit_cnt_r - 5'd1;
        if (bit_cnt_r == 5'd0) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // advance past leading zeros, keep at least one digit
        if (top_digit == '0 && rem_r > 5'd1) begin
          cell_ctrl.op = CELL_SHIFT;
          rem_nxt      = rem_r - 5'd1;
        end else if (pfx_r != 2'd0) begin
          state_nxt = ST_PREFIX;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_PREFIX: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt.last = 1'b0;
          if (!ptr_r) begin
            out_item_nxt.char_code = CH_MINUS;
          end else if (pfx_r == 2'd2) begin
            out_item_nxt.char_code = CH_ZERO;
          end else begin
            out_item_nxt.char_code = CH_X;
          end
          pfx_nxt = pfx_r - 2'd1;
          if (pfx_r == 2'd1) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_item_nxt.char_code = digit_char(top_digit, upper_r);
          out_item_nxt.last      = (rem_r == 5'd1);
          cell_ctrl.op           = CELL_SHIFT;
          rem_nxt                = rem_r - 5'd1;
          if (rem_r == 5'd1) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      bit_cnt_r   <= '0;
      rem_r       <= '0;
      pfx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      rem_r       <= rem_nxt;
      pfx_r       <= pfx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r      <= bin_nxt;
    top_sel_r  <= top_sel_nxt;
    ptr_r      <= ptr_nxt;
    upper_r    <= upper_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

// File: rtl/integer_to_ascii_digits.sv
// Binary to ASCII converter: takes a value and a format command, returns its
// characters most significant first, one per transfer, last flagged. A value
// occupies the block from its input transfer to the load of its last character.
// Decimal formats begin with the 32-step double-dabble pass through the row of
// 16 digit cells; every format then moves one digit a cycle toward the top
// cell, first past leading zeros, then out through the output register, where
// a stalled receiver holds the flow.
// Commands 5 to 7 are taken and dropped with no result.
// Depends on i2a_pkg, i2a_cell and i2a_ctrl.
`timescale 1ns / 1ps

module integer_to_ascii_digits (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  i2a_pkg::in_item_t   in_payload,
  output logic                out_valid,
  input  logic                out_ready,
  output i2a_pkg::out_item_t  out_payload
);
  import i2a_pkg::*;

  cell_ctrl_t                            cell_ctrl;
  logic [NUM_CELLS-1:0][DIGIT_W-1:0]     digits;
  logic [NUM_CELLS-1:0]                  carry;

  i2a_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_payload (in_payload),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_payload(out_payload),
    .digits     (digits),
    .cell_ctrl  (cell_ctrl)
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    logic              bit_in;
    logic [DIGIT_W-1:0] digit_in;
    logic              load_en;

    if (i == 0) begin : g_first
      assign bit_in   = cell_ctrl.ser_bit;
      assign digit_in = '0;
    end else begin : g_rest
      assign bit_in   = carry[i-1];
      assign digit_in = digits[i-1];
    end

    if (i < HEX32_DIGITS) begin : g_lo
      assign load_en = cell_ctrl.load_lo;
    end else begin : g_hi
      assign load_en = cell_ctrl.load_hi;
    end

    i2a_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .load_en   (load_en),
      .load_digit(in_payload.value[DIGIT_W*i +: DIGIT_W]),
      .bit_in    (bit_in),
      .digit_in  (digit_in),
      .digit     (digits[i]),
      .bit_out   (carry[i])
    );
  end

endmodule

// File: rtl/i2a_checker.sv
// Port-level checker for integer_to_ascii_digits, bound to the top level.
// Depends on i2a_pkg and integer_to_ascii_digits_assert.svh.
`timescale 1ns / 1ps
`include "integer_to_ascii_digits_assert.svh"

module i2a_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input i2a_pkg::in_item_t  in_payload,
  input logic               out_valid,
  input logic               out_ready,
  input i2a_pkg::out_item_t out_payload
);
  import i2a_pkg::*;

  logic [6:0] ch;
  logic       legal_char;

  assign ch = out_payload.char_code;
  assign legal_char = (ch >= CH_ZERO && ch <= 7'h39) ||
                      (ch >= CH_LOW_A && ch <= 7'h66) ||
                      (ch >= CH_UP_A && ch <= 7'h46) ||
                      (ch == CH_MINUS) || (ch == CH_X);

  `I2A_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload), "result changed while stalled")
  `I2A_ASSERT_NOW(a_char_legal, out_valid, legal_char, "illegal character code")
  `I2A_ASSERT_NOW(a_last_is_digit, out_valid && out_payload.last, ch != CH_MINUS && ch != CH_X, "run ends on sign or prefix")
  `I2A_ASSERT_NOW(a_busy_mid_run, out_valid && out_ready && !out_payload.last, !in_ready, "input taken before run finished")

endmodule

bind integer_to_ascii_digits i2a_checker u_i2a_checker (.*);

// File: test/integer_to_ascii_digits_tb.sv
// Testbench for integer_to_ascii_digits: directed table plus random values, every
// character checked against the table's text or a local model of the conversion.
// Depends on i2a_pkg and the integer_to_ascii_digits RTL.
`timescale 1ns / 1ps

module integer_to_ascii_digits_tb;
  import i2a_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int ITEMS_PER_PH = 32;
  localparam int DRAIN_CYCLES = 60;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_payload = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_payload;

  out_item_t   expected_chars[$];
  string       pending_text = "";
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          errors = 0;
  int          cycle_count = 0;

  logic [63:0] dir_value[$];
  logic [2:0]  dir_cmd[$];
  string       dir_text[$];

  integer_to_ascii_digits u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_payload (in_payload),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_payload(out_payload)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Work out the characters of one value, most significant first.
  function automatic void predict_chars(input in_item_t item);
    logic [63:0] mag;
    logic [31:0] word;
    logic [3:0]  digits[20];
    int          base;
    int          n;
    bit          upper;
    out_item_t   ch;
    if (item.command > CMD_PTR) return;
    base  = (item.command == CMD_SDEC || item.command == CMD_UDEC) ? 10 : 16;
    upper = (item.command == CMD_HEXU);
    word  = item.value[31:0];
    mag   = {32'd0, word};
    if (item.command == CMD_SDEC && word[31]) begin
      expected_chars.push_back('{char_code: CH_MINUS, last: 1'b0});
      word = 32'd0 - word;  // modulo 2^32, so the most negative value stays exact
      mag  = {32'd0, word};
    end else if (item.command == CMD_PTR) begin
      expected_chars.push_back('{char_code: CH_ZERO, last: 1'b0});
      expected_chars.push_back('{char_code: CH_X, last: 1'b0});
      mag = item.value;
    end
    n = 0;
    do begin
      digits[n] = 4'(mag % base);
      mag = mag / base;
      n++;
    end while (mag != 0);
    for (int i = n - 1; i >= 0; i--) begin
      if (digits[i] < 4'd10) begin
        ch.char_code = CH_ZERO + {3'b000, digits[i]};
      end else begin
        ch.char_code = (upper ? CH_UP_A : CH_LOW_A) + {3'b000, digits[i]} - 7'd10;
      end
      ch.last = (i == 0);
      expected_chars.push_back(ch);
    end
  endfunction

  function automatic void push_text(input string text);
    out_item_t ch;
    for (int i = 0; i < text.len(); i++) begin
      ch.char_code = 7'(text[i]);
      ch.last      = (i == text.len() - 1);
      expected_chars.push_back(ch);
    end
  endfunction

  // Queue expectations on input transfers, check characters on output transfers.
  always @(posedge clk) begin : check_chars
    out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (pending_text.len() != 0) begin
          push_text(pending_text);
        end else begin
          predict_chars(in_payload);
        end
      end
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          $error("char_code: expected none, actual %h", out_payload.char_code);
          errors++;
        end else begin
          want = expected_chars.pop_front();
          if (out_payload.char_code !== want.char_code) begin
            $error("char_code: expected %h, actual %h", want.char_code,
                   out_payload.char_code);
            errors++;
          end
          if (out_payload.last !== want.last) begin
            $error("last: expected %b, actual %b", want.last, out_payload.last);
            errors++;
          end
        end
      end
    end
  end

  task automatic add_row(input logic [63:0] value, input logic [2:0] command,
                         input string text);
    dir_value.push_back(value);
    dir_cmd.push_back(command);
    dir_text.push_back(text);
  endtask

  // Hold off for a random gap, then present one value and wait for its transfer.
  task automatic send_value(input logic [63:0] value, input logic [2:0] command,
                            input string text);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 60) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_payload   <= {value, command};
    pending_text <= text;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    logic [31:0] p;
    int          w;
    case ($urandom_range(4))
      0: v = {$urandom, $urandom};
      1: v = {$urandom, 32'($urandom_range(20))};
      2: begin
        w = $urandom_range(1, 64);
        v = {$urandom, $urandom} & ((64'd1 << w) - 64'd1);
      end
      3: begin
        case ($urandom_range(3))
          0: v = 64'h0000_0000_7fff_ffff;
          1: v = 64'h0000_0000_8000_0000;
          2: v = 64'h0000_0000_ffff_ffff;
          default: v = 64'h0000_0001_0000_0000;
        endcase
        v = v + 64'($urandom_range(2)) - 64'd1;
        if ($urandom_range(1)) v[63:33] = 31'($urandom);
      end
      default: begin
        // straddle a decimal digit-count boundary
        p = 32'd1;
        repeat ($urandom_range(9)) p = p * 32'd10;
        v = {$urandom, p + 32'($urandom_range(2)) - 32'd1};
      end
    endcase
    return v;
  endfunction

  initial begin
    logic [63:0] value;
    logic [2:0]  command;
    int          sent;

    add_row(64'h0, CMD_SDEC, "0");
    add_row(64'h0, CMD_UDEC, "0");
    add_row(64'h0, CMD_HEXL, "0");
    add_row(64'h0, CMD_HEXU, "0");
    add_row(64'h0, CMD_PTR, "0x0");
    add_row(64'h8000_0000, CMD_SDEC, "-2147483648");
    add_row(64'h7fff_ffff, CMD_SDEC, "2147483647");
    add_row(64'hffff_ffff, CMD_SDEC, "-1");
    add_row(64'h1, CMD_SDEC, "1");
    add_row(64'hffff_ffff, CMD_UDEC, "4294967295");
    add_row(64'hffff_ffff, CMD_HEXL, "ffffffff");
    add_row(64'hffff_ffff, CMD_HEXU, "FFFFFFFF");
    add_row(64'hffff_ffff_ffff_ffff, CMD_PTR, "0xffffffffffffffff");
    add_row(64'h8000_0000_0000_0000, CMD_PTR, "0x8000000000000000");
    add_row(64'hffff_ffff_0000_0000, CMD_SDEC, "0");
    add_row(64'hffff_ffff_0000_0000, CMD_HEXL, "0");
    add_row(64'hdead_beef_0000_000a, CMD_UDEC, "10");
    add_row(64'h0123_4567_89ab_cdef, CMD_PTR, "");
    add_row(64'h5555_5555_abcd_ef01, CMD_HEXU, "");
    add_row(64'haaaa_aaaa_89ab_cdef, CMD_HEXL, "");
    add_row(64'h0000_0001_0000_0000, CMD_PTR, "");
    add_row(64'h0000_0000_3b9a_c9ff, CMD_UDEC, "");
    add_row(64'h1234_5678_8765_4321, 3'd5, "");
    add_row(64'hffff_ffff_ffff_ffff, 3'd6, "");
    add_row(64'h0, 3'd7, "");

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < dir_value.size(); i++) begin
      send_value(dir_value[i], dir_cmd[i], dir_text[i]);
    end

    // Phases: no idling, sender idle, receiver stalling, both.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 59 : (ph == 3) ? 25 : 0;
      stall_pct <= (ph == 2) ? 59 : (ph == 3) ? 25 : 0;
      sent = 0;
      while (sent < ITEMS_PER_PH) begin
        value = pick_value();
        command = ($urandom_range(99) < 8) ? 3'($urandom_range(5, 7))
                                           : 3'($urandom_range(0, 4));
        send_value(value, command, "");
        if (command <= CMD_PTR) sent++;
      end
    end
    in_valid <= 1'b0;

    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: integer_to_ascii_digits.f
+incdir+rtl
rtl/i2a_pkg.sv
rtl/i2a_cell.sv
rtl/i2a_ctrl.sv
rtl/integer_to_ascii_digits.sv
rtl/i2a_checker.sv
test/integer_to_ascii_digits_tb.sv
